// ----- design/rctf_pkg.sv -----
// ----------------------------------------------------------------------------
// rctf_pkg: shared types and constants of the relay client table fan-out unit
// Operation, result kind codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package rctf_pkg;

  localparam int unsigned EpW    = 48;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PortW  = 16;
  localparam int unsigned SecW   = 32;
  localparam int unsigned TtlW   = 8;
  localparam int unsigned LenW   = 11;
  localparam int unsigned CountW = 6;

  localparam logic [EpW-1:0] EpBroadcast = '1;
  localparam logic [EpW-1:0] AdminReset  = 48'd1;
  localparam logic [TtlW-1:0] TtlReset   = 8'd10;

  localparam logic OpPacket = 1'b0;
  localparam logic OpTick   = 1'b1;

  localparam logic CfgAdmin = 1'b0;
  localparam logic CfgTtl   = 1'b1;

  typedef enum logic [1:0] {
    KindForward = 2'd0,
    KindDone    = 2'd1,
    KindAdmin   = 2'd2
  } kind_e;

  // classified packet handed from front to back
  typedef struct packed {
    logic           fan;      // normal packet: learn and fan out
    kind_e          kind;     // kind of the final beat
    logic [EpW-1:0] sender;
    logic [EpW-1:0] from;     // header source after fill
    logic           priv;
    logic [EpW-1:0] dest;
    logic [SecW-1:0] now;     // seconds count when the beat was accepted
  } cmd_t;

endpackage

// ----- design/rctf_front.sv -----
// ----------------------------------------------------------------------------
// rctf_front: input classifier
// Accepts items, counts seconds, classifies packets into back-end commands.
// ----------------------------------------------------------------------------
module rctf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [rctf_pkg::AddrW-1:0]    src_addr_i,
  input  logic [rctf_pkg::PortW-1:0]    src_port_i,
  input  logic [rctf_pkg::EpW-1:0]      hdr_from_i,
  input  logic [rctf_pkg::EpW-1:0]      hdr_to_i,
  input  logic [rctf_pkg::LenW-1:0]     length_i,
  input  logic [rctf_pkg::EpW-1:0]      admin_ep_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_stall_i,
  output rctf_pkg::cmd_t                cmd_o
);

  logic [rctf_pkg::SecW-1:0] now_q, now_d;
  logic                      acc;
  logic [rctf_pkg::EpW-1:0]  sender;

  assign in_stall_o  = cmd_stall_i;
  assign acc         = in_valid_i && !cmd_stall_i;
  assign sender      = {src_addr_i, src_port_i};
  // ticks are consumed here and never reach the queue
  assign cmd_valid_o = in_valid_i && (operation_i == rctf_pkg::OpPacket);

  always_comb begin
    now_d = now_q;
    if (acc && operation_i == rctf_pkg::OpTick) begin
      now_d = now_q + 1'b1;
    end
  end

  always_comb begin
    cmd_o.sender = sender;
    cmd_o.dest   = hdr_to_i;
    cmd_o.priv   = hdr_to_i != rctf_pkg::EpBroadcast;
    cmd_o.from   = hdr_from_i;
    cmd_o.now    = now_q;
    cmd_o.fan    = 1'b0;
    cmd_o.kind   = rctf_pkg::KindDone;
    if (length_i == '0) begin
      cmd_o.kind = rctf_pkg::KindDone;
    end else if (hdr_from_i == admin_ep_i) begin
      cmd_o.kind = rctf_pkg::KindAdmin;
    end else begin
      cmd_o.fan = 1'b1;
      if (hdr_from_i == '0) begin
        cmd_o.from = sender;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
    end else begin
      now_q <= now_d;
    end
  end

endmodule

// ----- design/rctf_queue.sv -----
// ----------------------------------------------------------------------------
// rctf_queue: command queue
// Two-entry FIFO decoupling the classifier from the table walker.
// ----------------------------------------------------------------------------
module rctf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_stall_o,
  input  rctf_pkg::cmd_t wr_cmd_i,
  output logic           rd_valid_o,
  input  logic           rd_take_i,
  output rctf_pkg::cmd_t rd_cmd_o
);

  rctf_pkg::cmd_t mem_q [2];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  assign wr_stall_o = cnt_q == 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_cmd_o   = mem_q[rp_q];
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_take_i && rd_valid_o;

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ pop;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/rctf_back.sv -----
// ----------------------------------------------------------------------------
// rctf_back: table walker
// Learns fan senders, walks slots one a cycle unless stalled, ages, fans out.
// ----------------------------------------------------------------------------
module rctf_back #(
  parameter int unsigned MaxClients = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_take_o,
  input  rctf_pkg::cmd_t                cmd_i,
  input  logic [rctf_pkg::TtlW-1:0]     ttl_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [rctf_pkg::AddrW-1:0]    dest_addr_o,
  output logic [rctf_pkg::PortW-1:0]    dest_port_o,
  output logic [rctf_pkg::EpW-1:0]      from_fill_o,
  output logic [rctf_pkg::CountW-1:0]   client_count_o,
  output logic                          table_full_o,
  output logic                          last_o
);

  localparam int unsigned IdxW = $clog2(MaxClients);
  localparam int unsigned CntW = $clog2(MaxClients + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(MaxClients - 1);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StLearn = 4'b0010,
    StWalk  = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  rctf_pkg::cmd_t cmd_q;
  logic [MaxClients-1:0]      valid_q, valid_d;
  logic [rctf_pkg::EpW-1:0]   ep_q  [MaxClients];
  logic [rctf_pkg::SecW-1:0]  exp_q [MaxClients];
  logic [CntW-1:0]            live_q, live_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic                       full_q, full_d;

  // learn search: hit and first free slot
  logic            hit, free;
  logic [IdxW-1:0] hit_idx, free_idx;
  logic            ep_we, exp_we;
  logic [IdxW-1:0] wr_idx;

  // output register
  logic                       ov_q, ov_d;
  logic [1:0]                 okind_q, okind_d;
  logic [rctf_pkg::EpW-1:0]   oep_q, oep_d;
  logic [rctf_pkg::EpW-1:0]   ofrom_q, ofrom_d;
  logic [rctf_pkg::CountW-1:0] ocnt_q, ocnt_d;
  logic                       ofull_q, ofull_d, olast_q, olast_d;
  logic                       ofree;

  assign ofree = !ov_q || !out_stall_i;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = MaxClients - 1; i >= 0; i--) begin
      if (valid_q[i] && ep_q[i] == cmd_q.sender) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free     = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    live_d     = live_q;
    idx_d      = idx_q;
    full_d     = full_q;
    cmd_take_o = 1'b0;
    ep_we      = 1'b0;
    exp_we     = 1'b0;
    wr_idx     = hit ? hit_idx : free_idx;
    ov_d       = ov_q && out_stall_i;
    okind_d    = okind_q;
    oep_d      = oep_q;
    ofrom_d    = ofrom_q;
    ocnt_d     = ocnt_q;
    ofull_d    = ofull_q;
    olast_d    = olast_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          full_d     = 1'b0;
          idx_d      = '0;
          state_d    = cmd_i.fan ? StLearn : StWalk;
        end
      end
      StLearn: begin
        if (hit) begin
          exp_we = 1'b1;
        end else if (free) begin
          ep_we           = 1'b1;
          exp_we          = 1'b1;
          valid_d[wr_idx] = 1'b1;
          live_d          = live_q + 1'b1;
        end else begin
          full_d = 1'b1;
        end
        state_d = StWalk;
      end
      StWalk: begin
        if (!valid_q[idx_q]) begin
          idx_d = idx_q + 1'b1;
        end else if (exp_q[idx_q] < cmd_q.now) begin
          valid_d[idx_q] = 1'b0;
          live_d         = live_q - 1'b1;
          idx_d          = idx_q + 1'b1;
        end else if (!cmd_q.fan || ep_q[idx_q] == cmd_q.sender
                     || (cmd_q.priv && ep_q[idx_q] != cmd_q.dest)) begin
          idx_d = idx_q + 1'b1;
        end else if (ofree) begin
          ov_d    = 1'b1;
          okind_d = rctf_pkg::KindForward;
          oep_d   = ep_q[idx_q];
          ofrom_d = cmd_q.from;
          ocnt_d  = '0;
          ofull_d = full_q;
          olast_d = 1'b0;
          idx_d   = idx_q + 1'b1;
        end
        if (idx_d != idx_q && idx_q == IdxLast) begin
          idx_d   = '0;
          state_d = StDone;
        end
      end
      StDone: begin
        if (ofree) begin
          ov_d    = 1'b1;
          okind_d = cmd_q.kind;
          oep_d   = '0;
          ofrom_d = cmd_q.from;
          ocnt_d  = rctf_pkg::CountW'(live_q);
          ofull_d = full_q;
          olast_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      cmd_q <= cmd_i;
    end
    if (ep_we) begin
      ep_q[wr_idx] <= cmd_q.sender;
    end
    if (exp_we) begin
      exp_q[wr_idx] <= cmd_q.now + rctf_pkg::SecW'(ttl_i);
    end
    okind_q <= okind_d;
    oep_q   <= oep_d;
    ofrom_q <= ofrom_d;
    ocnt_q  <= ocnt_d;
    ofull_q <= ofull_d;
    olast_q <= olast_d;
    idx_q   <= idx_d;
    full_q  <= full_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      live_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      live_q  <= live_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = okind_q;
  assign dest_addr_o    = oep_q[rctf_pkg::EpW-1:rctf_pkg::PortW];
  assign dest_port_o    = oep_q[rctf_pkg::PortW-1:0];
  assign from_fill_o    = ofrom_q;
  assign client_count_o = ocnt_q;
  assign table_full_o   = ofull_q;
  assign last_o         = olast_q;

endmodule

// ----- design/relay_client_table_fanout_unit.sv -----
// ----------------------------------------------------------------------------
// relay_client_table_fanout_unit: relay client learning table with fan-out
// Classifier, command queue and table walker for a packet relay.
// ----------------------------------------------------------------------------
// A packet beat learns or refreshes the sender (expiry = now + ttl), then the
// walker visits every slot once, one slot a cycle while the output is not
// stalled, removing expired entries and sending a forward beat to each other
// live client (only the matching client for a private packet), in slot order.
// A final beat (done or admin) closes the packet with last set and the live
// client count. Zero-length and admin packets only age the table. Tick beats
// advance the seconds count in the front end and produce no output; each
// packet carries the seconds count of its own accept, so ticks taken while
// packets wait in the queue do not reach them. In the walker a normal packet
// passes a take step, a learn step, a visit to each slot and the final beat;
// ageing-only packets skip the learn step. A two-entry queue lets new beats
// be accepted while the walker is busy.
// Configuration registers must be written only while the unit is idle.
module relay_client_table_fanout_unit #(
  parameter int unsigned MaxClients = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rctf_pkg::EpW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [rctf_pkg::AddrW-1:0]    src_addr_i,
  input  logic [rctf_pkg::PortW-1:0]    src_port_i,
  input  logic [rctf_pkg::EpW-1:0]      hdr_from_i,
  input  logic [rctf_pkg::EpW-1:0]      hdr_to_i,
  input  logic [rctf_pkg::LenW-1:0]     length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [rctf_pkg::AddrW-1:0]    dest_addr_o,
  output logic [rctf_pkg::PortW-1:0]    dest_port_o,
  output logic [rctf_pkg::EpW-1:0]      from_fill_o,
  output logic [rctf_pkg::CountW-1:0]   client_count_o,
  output logic                          table_full_o,
  output logic                          last_o
);

  logic [rctf_pkg::EpW-1:0]  admin_q;
  logic [rctf_pkg::TtlW-1:0] ttl_q;
  logic                      f_valid, f_stall, q_valid, q_take;
  rctf_pkg::cmd_t            f_cmd, q_cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      admin_q <= rctf_pkg::AdminReset;
      ttl_q   <= rctf_pkg::TtlReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rctf_pkg::CfgAdmin) begin
        admin_q <= cfg_data_i;
      end else begin
        ttl_q <= cfg_data_i[rctf_pkg::TtlW-1:0];
      end
    end
  end

  rctf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .src_addr_i  (src_addr_i),
    .src_port_i  (src_port_i),
    .hdr_from_i  (hdr_from_i),
    .hdr_to_i    (hdr_to_i),
    .length_i    (length_i),
    .admin_ep_i  (admin_q),
    .cmd_valid_o (f_valid),
    .cmd_stall_i (f_stall),
    .cmd_o       (f_cmd)
  );

  rctf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_stall_o (f_stall),
    .wr_cmd_i   (f_cmd),
    .rd_valid_o (q_valid),
    .rd_take_i  (q_take),
    .rd_cmd_o   (q_cmd)
  );

  rctf_back #(
    .MaxClients (MaxClients)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_take_o     (q_take),
    .cmd_i          (q_cmd),
    .ttl_i          (ttl_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .dest_addr_o    (dest_addr_o),
    .dest_port_o    (dest_port_o),
    .from_fill_o    (from_fill_o),
    .client_count_o (client_count_o),
    .table_full_o   (table_full_o),
    .last_o         (last_o)
  );

endmodule

// ----- verif/tb_relay_client_table_fanout_unit.sv -----
// ----------------------------------------------------------------------------
// tb_relay_client_table_fanout_unit: self-checking bench for the relay table
// A driver pops packet and tick beats from a queue. A table model predicts
// every result beat on input accept, and a monitor checks output beats in
// order. Phases vary the registers and the idle and stall rates.
// ----------------------------------------------------------------------------
module tb_relay_client_table_fanout_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots  = 32;
  localparam int PoolSize  = 40;
  localparam int IdleLimit = 20000;
  localparam int DrainWait = 120;

  typedef struct {
    logic                       op;
    logic [rctf_pkg::AddrW-1:0] addr;
    logic [rctf_pkg::PortW-1:0] port;
    logic [rctf_pkg::EpW-1:0]   from;
    logic [rctf_pkg::EpW-1:0]   to;
    logic [rctf_pkg::LenW-1:0]  len;
  } pkt_t;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [rctf_pkg::AddrW-1:0]  addr;
    logic [rctf_pkg::PortW-1:0]  port;
    logic [rctf_pkg::EpW-1:0]    from;
    logic [rctf_pkg::CountW-1:0] count;
    logic                        full;
    logic                        last;
  } beat_t;

  logic clk_i, rst_ni;
  logic cfg_we, cfg_idx;
  logic [rctf_pkg::EpW-1:0] cfg_data;
  logic in_valid, in_stall;
  logic op;
  logic [rctf_pkg::AddrW-1:0] src_addr;
  logic [rctf_pkg::PortW-1:0] src_port;
  logic [rctf_pkg::EpW-1:0] hdr_from, hdr_to;
  logic [rctf_pkg::LenW-1:0] len;
  logic out_valid, out_stall;
  logic [1:0] kind;
  logic [rctf_pkg::AddrW-1:0] dest_addr;
  logic [rctf_pkg::PortW-1:0] dest_port;
  logic [rctf_pkg::EpW-1:0] from_fill;
  logic [rctf_pkg::CountW-1:0] client_count;
  logic table_full, last;

  relay_client_table_fanout_unit dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(op), .src_addr_i(src_addr), .src_port_i(src_port),
    .hdr_from_i(hdr_from), .hdr_to_i(hdr_to), .length_i(len),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .dest_addr_o(dest_addr), .dest_port_o(dest_port),
    .from_fill_o(from_fill), .client_count_o(client_count),
    .table_full_o(table_full), .last_o(last)
  );

  // clock and a single reset at time zero
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // table model state, own copy of the registers
  logic [rctf_pkg::EpW-1:0]  m_admin;
  logic [rctf_pkg::TtlW-1:0] m_ttl;
  logic [rctf_pkg::SecW-1:0] m_now;
  logic                      m_vld[NumSlots];
  logic [rctf_pkg::EpW-1:0]  m_ep[NumSlots];
  logic [rctf_pkg::SecW-1:0] m_exp[NumSlots];
  int                        m_live;

  pkt_t  pending[$];
  beat_t expected_beats[$];
  logic [rctf_pkg::EpW-1:0] pool[PoolSize];
  int errors = 0;
  int src_idle_pct = 0, rx_stall_pct = 0;
  int hold_req = 0;   // bump to request a long receiver hold-off

  function automatic beat_t mk_beat(logic [1:0] k, logic [rctf_pkg::EpW-1:0] ep,
                                    logic [rctf_pkg::EpW-1:0] f,
                                    int cnt, logic full, logic lst);
    beat_t b;
    b.kind = k; b.addr = ep[47:16]; b.port = ep[15:0]; b.from = f;
    b.count = cnt[rctf_pkg::CountW-1:0]; b.full = full; b.last = lst;
    return b;
  endfunction

  // age the table and, when fanning out, queue the forward beats
  task automatic walk_table(logic fan, logic [rctf_pkg::EpW-1:0] snd, logic priv,
                            logic [rctf_pkg::EpW-1:0] dst, logic [rctf_pkg::EpW-1:0] f,
                            logic full);
    for (int i = 0; i < NumSlots; i++) begin
      if (!m_vld[i]) continue;
      if (m_exp[i] < m_now) begin
        m_vld[i] = 1'b0;
        m_live--;
        continue;
      end
      if (!fan || m_ep[i] == snd) continue;
      if (priv && m_ep[i] != dst) continue;
      expected_beats.push_back(mk_beat(rctf_pkg::KindForward, m_ep[i], f, 0, full, 1'b0));
    end
  endtask

  task automatic predict_packet(pkt_t p);
    logic [rctf_pkg::EpW-1:0] snd, f;
    logic full;
    int slot;
    snd = {p.addr, p.port};
    f = p.from;
    full = 1'b0;
    slot = -1;
    if (p.op == rctf_pkg::OpTick) begin
      m_now++;
    end else if (p.len == 0) begin
      walk_table(1'b0, '0, 1'b0, '0, f, 1'b0);
      expected_beats.push_back(mk_beat(rctf_pkg::KindDone, '0, f, m_live, 1'b0, 1'b1));
    end else if (f == m_admin) begin
      walk_table(1'b0, '0, 1'b0, '0, f, 1'b0);
      expected_beats.push_back(mk_beat(rctf_pkg::KindAdmin, '0, f, m_live, 1'b0, 1'b1));
    end else begin
      if (f == '0) f = snd;
      // refresh a known sender, even a stale one, else take the first free slot
      for (int i = 0; i < NumSlots; i++)
        if (slot < 0 && m_vld[i] && m_ep[i] == snd) slot = i;
      for (int i = 0; i < NumSlots; i++)
        if (slot < 0 && !m_vld[i]) begin
          slot = i;
          m_vld[i] = 1'b1;
          m_ep[i] = snd;
          m_live++;
        end
      if (slot < 0) full = 1'b1;
      else m_exp[slot] = m_now + rctf_pkg::SecW'(m_ttl);
      walk_table(1'b1, snd, p.to != rctf_pkg::EpBroadcast, p.to, f, full);
      expected_beats.push_back(mk_beat(rctf_pkg::KindDone, '0, f, m_live, full, 1'b1));
    end
  endtask

  // driver: one beat in flight, predicted when accepted
  pkt_t cur;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      op <= rctf_pkg::OpPacket; src_addr <= '0; src_port <= '0;
      hdr_from <= '0; hdr_to <= '0; len <= '0;
    end else begin
      if (in_valid && !in_stall) predict_packet(cur);
      if (!in_valid || !in_stall) begin
        if (pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cur = pending.pop_front();
          in_valid <= 1'b1;
          op <= cur.op; src_addr <= cur.addr; src_port <= cur.port;
          hdr_from <= cur.from; hdr_to <= cur.to; len <= cur.len;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off counted here on request
  int hold_seen = 0, hold_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // monitor: each output beat against the oldest prediction
  always @(posedge clk_i) begin
    beat_t got, want;
    if (rst_ni && out_valid && !out_stall) begin
      got = '{kind, dest_addr, dest_port, from_fill, client_count, table_full, last};
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat expected none actual %h", $realtime, got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: beat mismatch expected %h actual %h", $realtime, want, got);
        end
      end
    end
  end

  // watchdog: cycles with work outstanding and no beat moving on either side
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending.size() == 0 && !in_valid && expected_beats.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic pkt_t mk_pkt(logic o, logic [rctf_pkg::EpW-1:0] snd,
                                  logic [rctf_pkg::EpW-1:0] f,
                                  logic [rctf_pkg::EpW-1:0] t, int l);
    pkt_t p;
    p.op = o; p.addr = snd[47:16]; p.port = snd[15:0];
    p.from = f; p.to = t; p.len = l[rctf_pkg::LenW-1:0];
    return p;
  endfunction

  function automatic logic [rctf_pkg::EpW-1:0] rnd_ep();
    return {$urandom(), 16'($urandom())};
  endfunction

  function automatic logic [rctf_pkg::EpW-1:0] pool_ep();
    return pool[$urandom_range(PoolSize-1)];
  endfunction

  // mostly well-formed traffic from a client pool larger than the table
  function automatic pkt_t rnd_pkt();
    int r, l;
    logic [rctf_pkg::EpW-1:0] f, t;
    r = $urandom_range(99);
    l = ($urandom_range(19) == 0) ? 2047 : $urandom_range(1500, 1);
    if (r < 15)
      return mk_pkt(rctf_pkg::OpTick, rnd_ep(), rnd_ep(), rnd_ep(), $urandom_range(2047));
    if (r < 20) return mk_pkt(rctf_pkg::OpPacket, pool_ep(), rnd_ep(), rnd_ep(), 0);
    if (r < 25) return mk_pkt(rctf_pkg::OpPacket, pool_ep(), m_admin, rnd_ep(), l);
    if (r < 30) return mk_pkt(rctf_pkg::OpPacket, rnd_ep(), rnd_ep(), rnd_ep(), l);
    f = ($urandom_range(4) == 0) ? pool_ep() : '0;
    t = ($urandom_range(3) == 0) ? pool_ep() : rctf_pkg::EpBroadcast;
    return mk_pkt(rctf_pkg::OpPacket, pool_ep(), f, t, l);
  endfunction

  task automatic drain();
    wait (pending.size() == 0 && !in_valid && expected_beats.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [rctf_pkg::EpW-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == rctf_pkg::CfgAdmin) m_admin = data;
    else m_ttl = data[rctf_pkg::TtlW-1:0];
  endtask

  task automatic random_batch(int n);
    repeat (n) pending.push_back(rnd_pkt());
  endtask

  initial begin
    cfg_we = 1'b0; cfg_idx = rctf_pkg::CfgAdmin; cfg_data = '0;
    m_admin = rctf_pkg::AdminReset; m_ttl = rctf_pkg::TtlReset; m_now = '0; m_live = 0;
    for (int i = 0; i < NumSlots; i++) begin
      m_vld[i] = 1'b0; m_ep[i] = '0; m_exp[i] = '0;
    end
    for (int i = 0; i < PoolSize; i++) pool[i] = rnd_ep();
    pool[0] = '1;
    pool[1] = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every kind of final beat, private, expiry, stale
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[2], '0, rctf_pkg::EpBroadcast, 0));
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[0], '0, rctf_pkg::EpBroadcast, 1500));
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[1], '0, rctf_pkg::EpBroadcast, 1));
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[2], '0, rctf_pkg::EpBroadcast, 2047));
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[3], pool[5], rctf_pkg::EpBroadcast, 64));
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[4], '0, pool[2], 64));  // private, known
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[4], '0, pool[9], 64));  // private, unknown
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[4], '0, '0, 64));
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[6], rctf_pkg::AdminReset,
                             rctf_pkg::EpBroadcast, 100));                    // admin
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[6], '1, rctf_pkg::EpBroadcast, 0));
    repeat (11) pending.push_back(mk_pkt(rctf_pkg::OpTick, '1, '1, '1, 2047));  // expire
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[4], '0, rctf_pkg::EpBroadcast, 10));
    pending.push_back(mk_pkt(rctf_pkg::OpPacket, pool[7], '0, rctf_pkg::EpBroadcast, 10));
    pending.push_back(mk_pkt(rctf_pkg::OpTick, '0, '0, '0, 0));
    drain();

    random_batch(35);
    // sender pause until everything is out, then more traffic
    wait (pending.size() == 0 && !in_valid && expected_beats.size() == 0);
    random_batch(35);
    drain();

    write_reg(rctf_pkg::CfgAdmin, '0);          // zero header source now means admin
    write_reg(rctf_pkg::CfgTtl, 48'd1);
    src_idle_pct = 84; rx_stall_pct = 0;
    random_batch(70);
    drain();

    write_reg(rctf_pkg::CfgAdmin, '1);
    write_reg(rctf_pkg::CfgTtl, 48'd255);       // long life: the table fills up
    src_idle_pct = 0; rx_stall_pct = 84;
    random_batch(70);
    drain();

    write_reg(rctf_pkg::CfgAdmin, pool[3]);
    write_reg(rctf_pkg::CfgTtl, 48'hFFFF_FFFF_FF03);  // upper bits ignored
    src_idle_pct = 36; rx_stall_pct = 36;
    hold_req = 1;                     // input backs up behind a long hold-off
    random_batch(70);
    drain();

    write_reg(rctf_pkg::CfgAdmin, rnd_ep());
    write_reg(rctf_pkg::CfgTtl, 48'd0);         // entry lives through this second only
    src_idle_pct = 0; rx_stall_pct = 0;
    random_batch(70);
    drain();

    if (errors == 0 && expected_beats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
